[hdl/line_edit_buffer_core_defines.svh]
// Assertion macros used by the line edit buffer datapath.
`ifndef LINE_EDIT_BUFFER_CORE_DEFINES_SVH
`define LINE_EDIT_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LEBC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define LEBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lebc_pkg.sv]
// Shared constants, key codes and controller/datapath interface types.
`timescale 1ns / 1ps

package lebc_pkg;

	localparam int BUFFER_DEPTH_DEF = 64;
	localparam int KEY_W = 8;
	localparam int CAP_W = 7;
	localparam int KIND_W = 2;
	localparam int POS_OUT_W = 6;
	// wide enough to compare positions against a depth of up to 256
	localparam int CMP_W = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// key codes
	localparam logic [KEY_W-1:0] KEY_LEFT      = 8'd75;
	localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'd77;
	localparam logic [KEY_W-1:0] KEY_HOME      = 8'd71;
	localparam logic [KEY_W-1:0] KEY_END       = 8'd79;
	localparam logic [KEY_W-1:0] KEY_DELETE    = 8'd83;
	localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'd8;
	localparam logic [KEY_W-1:0] KEY_ENTER     = 8'd13;
	localparam logic [KEY_W-1:0] PREFIX_A      = 8'd0;
	localparam logic [KEY_W-1:0] PREFIX_B      = 8'd224;
	localparam logic [KEY_W-1:0] PRINT_LO      = 8'd32;
	localparam logic [KEY_W-1:0] PRINT_HI      = 8'd126;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	// commands from controller to datapath
	typedef struct packed {
		logic key_load;
		logic ext_set;
		logic ext_clr;
		logic cur_dec;
		logic cur_inc;
		logic cur_home;
		logic cur_end;
		logic len_dec;
		logic ins_start;
		logic del_start;
		logic del_bksp;
		logic shift_ins;
		logic shift_del;
		logic put_key;
		logic stream_start;
		logic stream_rd;
		logic ptr_inc;
		logic line_clr;
		logic out_status;
		logic out_char;
		logic out_empty;
	} lebc_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic ext_pending;
		logic key_prefix;
		logic key_bksp;
		logic key_enter;
		logic key_print;
		logic key_left;
		logic key_right;
		logic key_home;
		logic key_end;
		logic key_del;
		logic cur_zero;
		logic cur_lt_len;
		logic cur_p1_lt_len;
		logic len_zero;
		logic can_insert;
		logic ins_done;
		logic ptr_at_end;
		logic out_free;
	} lebc_sts_t;

endpackage

[hdl/lebc_ctrl.sv]
// Controller state machine: sequences decode, shifts, streaming and result loads.
`timescale 1ns / 1ps

module lebc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lebc_pkg::lebc_sts_t sts,
	output lebc_pkg::lebc_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT_INS,
		ST_INS_PUT,
		ST_SHIFT_DEL,
		ST_STATUS,
		ST_STREAM_RD,
		ST_STREAM_OUT,
		ST_EMPTY_OUT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// one key at a time, taken only between operations
	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.key_load = 1'b1;
					state_nxt    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_STATUS;
				if (sts.ext_pending) begin
					cmd.ext_clr = 1'b1;
					if (sts.key_left) begin
						cmd.cur_dec = !sts.cur_zero;
					end else if (sts.key_right) begin
						cmd.cur_inc = sts.cur_lt_len;
					end else if (sts.key_home) begin
						cmd.cur_home = 1'b1;
					end else if (sts.key_end) begin
						cmd.cur_end = 1'b1;
					end else if (sts.key_del && sts.cur_lt_len) begin
						if (sts.cur_p1_lt_len) begin
							cmd.del_start = 1'b1;
							state_nxt     = ST_SHIFT_DEL;
						end else begin
							cmd.len_dec = 1'b1;
						end
					end
				end else if (sts.key_prefix) begin
					cmd.ext_set = 1'b1;
				end else if (sts.key_bksp) begin
					if (!sts.cur_zero) begin
						cmd.cur_dec = 1'b1;
						if (sts.cur_lt_len) begin
							cmd.del_start = 1'b1;
							cmd.del_bksp  = 1'b1;
							state_nxt     = ST_SHIFT_DEL;
						end else begin
							cmd.len_dec = 1'b1;
						end
					end
				end else if (sts.key_enter) begin
					if (sts.len_zero) begin
						state_nxt = ST_EMPTY_OUT;
					end else begin
						cmd.stream_start = 1'b1;
						state_nxt        = ST_STREAM_RD;
					end
				end else if (sts.key_print && sts.can_insert) begin
					if (sts.cur_lt_len) begin
						cmd.ins_start = 1'b1;
						state_nxt     = ST_SHIFT_INS;
					end else begin
						state_nxt = ST_INS_PUT;
					end
				end
			end
			ST_SHIFT_INS: begin
				cmd.shift_ins = 1'b1;
				if (sts.ins_done) begin
					state_nxt = ST_INS_PUT;
				end
			end
			ST_INS_PUT: begin
				cmd.put_key = 1'b1;
				state_nxt   = ST_STATUS;
			end
			ST_SHIFT_DEL: begin
				cmd.shift_del = 1'b1;
				if (sts.ptr_at_end) begin
					cmd.len_dec = 1'b1;
					state_nxt   = ST_STATUS;
				end
			end
			ST_STATUS: begin
				if (sts.out_free) begin
					cmd.out_status = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			ST_STREAM_RD: begin
				cmd.stream_rd = 1'b1;
				state_nxt     = ST_STREAM_OUT;
			end
			ST_STREAM_OUT: begin
				if (sts.out_free) begin
					cmd.out_char = 1'b1;
					if (sts.ptr_at_end) begin
						cmd.line_clr = 1'b1;
						state_nxt    = ST_IDLE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_nxt   = ST_STREAM_RD;
					end
				end
			end
			ST_EMPTY_OUT: begin
				if (sts.out_free) begin
					cmd.out_empty = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[hdl/lebc_datapath.sv]
// Datapath: line store memory, cursor/length registers, key decode, result register.
`timescale 1ns / 1ps
`include "line_edit_buffer_core_defines.svh"

module lebc_datapath #(
	parameter int BUFFER_DEPTH = lebc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lebc_pkg::KEY_W-1:0]     key_in,
	input  logic                           cfg_valid,
	input  logic [lebc_pkg::CAP_W-1:0]     cfg_data,
	input  lebc_pkg::lebc_cmd_t            cmd,
	output lebc_pkg::lebc_sts_t            sts,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [lebc_pkg::KIND_W-1:0]    out_kind,
	output logic [lebc_pkg::POS_OUT_W-1:0] out_cursor,
	output logic [lebc_pkg::POS_OUT_W-1:0] out_length,
	output logic [lebc_pkg::KEY_W-1:0]     out_char,
	output logic                           out_last
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int CMP_W = lebc_pkg::CMP_W;

	logic [lebc_pkg::KEY_W-1:0] key_q;
	logic                       ext_q;
	logic [lebc_pkg::CAP_W-1:0] cap_q;
	logic [IDX_W-1:0]           cur_q;
	logic [IDX_W-1:0]           len_q;
	logic [IDX_W-1:0]           ptr_q;
	logic [IDX_W-1:0]           wb_addr_q;
	logic                       wb_valid_q;
	logic                       wb_key_q;
	logic [lebc_pkg::KEY_W-1:0] rd_data_q;
	logic [lebc_pkg::KEY_W-1:0] mem [BUFFER_DEPTH];
	logic                       out_valid_q;

	logic [CMP_W-1:0] cur_w;
	logic [CMP_W-1:0] len_w;
	logic [CMP_W-1:0] ptr_w;
	logic [CMP_W-1:0] cap_w;
	logic             rd_en;
	logic             out_free;

	assign cur_w = CMP_W'(cur_q);
	assign len_w = CMP_W'(len_q);
	assign ptr_w = CMP_W'(ptr_q);
	// capacity in use saturates at the physical depth
	assign cap_w = (CMP_W'(cap_q) > CMP_W'(BUFFER_DEPTH)) ? CMP_W'(BUFFER_DEPTH) : CMP_W'(cap_q);

	assign rd_en    = cmd.shift_ins | cmd.shift_del | cmd.stream_rd;
	assign out_free = !out_valid_q || out_ready;

	// key decode and position compares
	always_comb begin
		sts.ext_pending   = ext_q;
		sts.key_prefix    = (key_q == lebc_pkg::PREFIX_A) || (key_q == lebc_pkg::PREFIX_B);
		sts.key_bksp      = (key_q == lebc_pkg::KEY_BACKSPACE);
		sts.key_enter     = (key_q == lebc_pkg::KEY_ENTER);
		sts.key_print     = (key_q >= lebc_pkg::PRINT_LO) && (key_q <= lebc_pkg::PRINT_HI);
		sts.key_left      = (key_q == lebc_pkg::KEY_LEFT);
		sts.key_right     = (key_q == lebc_pkg::KEY_RIGHT);
		sts.key_home      = (key_q == lebc_pkg::KEY_HOME);
		sts.key_end       = (key_q == lebc_pkg::KEY_END);
		sts.key_del       = (key_q == lebc_pkg::KEY_DELETE);
		sts.cur_zero      = (cur_w == '0);
		sts.cur_lt_len    = (cur_w < len_w);
		sts.cur_p1_lt_len = ((cur_w + 1'b1) < len_w);
		sts.len_zero      = (len_w == '0);
		sts.can_insert    = ((len_w + 1'b1) < cap_w);
		sts.ins_done      = (ptr_q == cur_q);
		sts.ptr_at_end    = ((ptr_w + 1'b1) == len_w);
		sts.out_free      = out_free;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q      <= 1'b0;
			cap_q      <= lebc_pkg::CAP_RESET;
			cur_q      <= '0;
			len_q      <= '0;
			wb_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.ext_set) begin
				ext_q <= 1'b1;
			end else if (cmd.ext_clr) begin
				ext_q <= 1'b0;
			end
			// cursor
			if (cmd.line_clr || cmd.cur_home) begin
				cur_q <= '0;
			end else if (cmd.cur_end) begin
				cur_q <= len_q;
			end else if (cmd.cur_dec) begin
				cur_q <= cur_q - 1'b1;
			end else if (cmd.cur_inc || cmd.put_key) begin
				cur_q <= cur_q + 1'b1;
			end
			// length
			if (cmd.line_clr) begin
				len_q <= '0;
			end else if (cmd.len_dec) begin
				len_q <= len_q - 1'b1;
			end else if (cmd.put_key) begin
				len_q <= len_q + 1'b1;
			end
			wb_valid_q <= cmd.shift_ins | cmd.shift_del | cmd.put_key;
		end
	end

	// pointer, delayed write address and key latch
	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= key_in;
		end
		if (cmd.ins_start) begin
			ptr_q <= len_q - 1'b1;
		end else if (cmd.del_start) begin
			ptr_q <= cmd.del_bksp ? cur_q : cur_q + 1'b1;
		end else if (cmd.stream_start) begin
			ptr_q <= '0;
		end else if (cmd.shift_ins) begin
			ptr_q <= ptr_q - 1'b1;
		end else if (cmd.shift_del || cmd.ptr_inc) begin
			ptr_q <= ptr_q + 1'b1;
		end
		// a shifted entry is written back in the cycle after its read
		if (cmd.shift_ins) begin
			wb_addr_q <= ptr_q + 1'b1;
		end else if (cmd.shift_del) begin
			wb_addr_q <= ptr_q - 1'b1;
		end else if (cmd.put_key) begin
			wb_addr_q <= cur_q;
		end
		wb_key_q <= cmd.put_key;
	end

	// line store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wb_valid_q) begin
			mem[wb_addr_q] <= wb_key_q ? key_q : rd_data_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[ptr_q];
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_status || cmd.out_char || cmd.out_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.out_status) begin
			out_kind   <= lebc_pkg::KIND_STATUS;
			out_cursor <= cur_w[lebc_pkg::POS_OUT_W-1:0];
			out_length <= len_w[lebc_pkg::POS_OUT_W-1:0];
			out_char   <= '0;
			out_last   <= 1'b1;
		end else if (cmd.out_char) begin
			out_kind   <= lebc_pkg::KIND_CHAR;
			out_cursor <= '0;
			out_length <= '0;
			out_char   <= rd_data_q;
			out_last   <= sts.ptr_at_end;
		end else if (cmd.out_empty) begin
			out_kind   <= lebc_pkg::KIND_EMPTY;
			out_cursor <= '0;
			out_length <= '0;
			out_char   <= '0;
			out_last   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`LEBC_ASSERT_IMPL(a_cur_le_len, 1'b1, cur_q <= len_q, "cursor beyond line length")
	`LEBC_ASSERT_IMPL(a_rd_wb_apart, rd_en && wb_valid_q, ptr_q != wb_addr_q, "read hits pending write")
	`LEBC_ASSERT_IMPL(a_load_free, cmd.out_status || cmd.out_char || cmd.out_empty, out_free, "result overwritten")
	`LEBC_ASSERT_NEXT(a_put_grows, cmd.put_key, len_q == IDX_W'($past(len_q) + 1'b1), "insert length")

endmodule

[hdl/line_edit_buffer_core.sv]
// Line edit buffer top level: key stream in, status and line stream out.
// A key without a shift goes from decode to the status state; the next key is taken in idle.
// Insert and delete shift each character after the cursor (up to BUFFER_DEPTH-2) first,
// and insert then writes the key. Enter streams the line a character at a time, each
// read before it is output: the line store has one registered read port.
// Reset (arst_n low, asynchronous) clears cursor, length, prefix flag and the result valid, and
// sets capacity to 64; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module line_edit_buffer_core #(
	parameter int BUFFER_DEPTH = lebc_pkg::BUFFER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] key_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [5:0] cursor_now, [11:6] length_now, [19:12] out_char
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data   // [6:0] capacity
);

	lebc_pkg::lebc_cmd_t cmd;
	lebc_pkg::lebc_sts_t sts;

	logic [lebc_pkg::POS_OUT_W-1:0] out_cursor;
	logic [lebc_pkg::POS_OUT_W-1:0] out_length;
	logic [lebc_pkg::KEY_W-1:0]     out_char;

	// capacity writes are always taken
	assign cfg_ready = 1'b1;

	lebc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lebc_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_in     (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_kind   (m_tuser),
		.out_cursor (out_cursor),
		.out_length (out_length),
		.out_char   (out_char),
		.out_last   (m_tlast)
	);

	// pack result fields, zero pad to whole bytes
	assign m_tdata = {4'b0000, out_char, out_length, out_cursor};

endmodule
